### design/rrt_pkg.sv
// shared types and constants for the ranked record table
// record layout, opcodes, status codes, controller states, memory request
// no dependencies
package rrt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int IN_DATA_W   = 128;
	localparam int OUT_DATA_W  = 136;
	localparam int USER_W      = 2;

	localparam logic [2:0] CLASS_MIN = 3'd1;
	localparam logic [2:0] CLASS_MAX = 3'd4;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_FIND_ID,
		OP_FIND_SCORE,
		OP_READ_RANK
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_NOT_FOUND,
		ST_FULL,
		ST_BAD_CLASS
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_SCAN,
		S_INS_WRITE,
		S_FIND,
		S_RANK,
		S_EMPTY
	} state_t;

	typedef struct packed {
		logic [9:0]  score;
		logic [31:0] student_id;
		logic [2:0]  class_num;
		logic [63:0] name_head;
		logic [7:0]  name_tail;
	} record_t;

	typedef struct packed {
		opcode_t     opcode;
		record_t     rec;
		logic [5:0]  rank_index;
	} item_t;

	typedef struct packed {
		status_t     status;
		record_t     rec;
		logic [5:0]  rank;
		logic [6:0]  entry_total;
	} result_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		record_t          wr_data;
	} mem_req_t;

endpackage

### design/rrt_mem.sv
// record memory: one write port, one read port, registered read data
// depends on rrt_pkg
module rrt_mem (
	input  logic              clk,
	input  rrt_pkg::mem_req_t req,
	output rrt_pkg::record_t  rd_data
);
	import rrt_pkg::*;

	record_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

### design/rrt_ctrl.sv
// sequencer for the ranked record table: insert shift, scans, rank read
// depends on rrt_pkg; drives the record memory through a mem_req_t
module rrt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rrt_pkg::item_t    item,
	input  logic              out_free,
	output logic              res_valid,
	output rrt_pkg::result_t  res,
	output rrt_pkg::mem_req_t req,
	input  rrt_pkg::record_t  rd_data
);
	import rrt_pkg::*;

	state_t           state_q, state_d;
	item_t            item_q;
	logic [IDX_W-1:0] ptr_q, ptr_d;
	logic [CNT_W-1:0] fill_q, fill_d;
	status_t          status_q, status_d;

	logic accept;
	logic bad_class;
	logic full;
	logic rank_ok;
	logic goes_after;
	logic hit;
	logic last;

	assign accept    = in_valid && in_ready;
	assign bad_class = (item.rec.class_num < CLASS_MIN) || (item.rec.class_num > CLASS_MAX);
	assign full      = (fill_q == CNT_W'(TABLE_DEPTH));
	assign rank_ok   = (CNT_W'(item.rank_index) < fill_q);

	// stored entry ranks after the new record
	assign goes_after = (rd_data.score < item_q.rec.score) ||
		((rd_data.score == item_q.rec.score) &&
		 (rd_data.class_num >= item_q.rec.class_num));

	assign hit  = (item_q.opcode == OP_FIND_ID) ?
		(rd_data.student_id == item_q.rec.student_id) :
		(rd_data.score == item_q.rec.score);
	assign last = ((CNT_W'(ptr_q) + CNT_W'(1)) == fill_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (item.opcode)
						OP_INSERT: begin
							if (bad_class || full) state_d = S_EMPTY;
							else if (fill_q == '0) state_d = S_INS_WRITE;
							else                   state_d = S_INS_SCAN;
						end
						OP_FIND_ID, OP_FIND_SCORE: begin
							state_d = (fill_q == '0) ? S_EMPTY : S_FIND;
						end
						OP_READ_RANK: begin
							state_d = rank_ok ? S_RANK : S_EMPTY;
						end
						default: state_d = S_EMPTY;
					endcase
				end
			end
			S_INS_SCAN: begin
				if (!goes_after || ptr_q == '0) state_d = S_INS_WRITE;
			end
			S_INS_WRITE, S_RANK, S_EMPTY: begin
				if (out_free) state_d = S_IDLE;
			end
			S_FIND: begin
				if (hit) begin
					if (out_free) state_d = S_IDLE;
				end else if (last) begin
					state_d = S_EMPTY;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		res_valid   = 1'b0;
		res         = '0;
		res.status  = status_q;
		res.entry_total = 7'(fill_q);
		req         = '0;
		ptr_d       = ptr_q;
		fill_d      = fill_q;
		status_d    = status_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					req.rd_en = 1'b1;
					status_d  = ST_NOT_FOUND;
					case (item.opcode)
						OP_INSERT: begin
							// class check ranks ahead of the full check
							status_d = bad_class ? ST_BAD_CLASS :
								(full ? ST_FULL : ST_NOT_FOUND);
							ptr_d = (fill_q == '0) ? '0 : IDX_W'(fill_q - CNT_W'(1));
						end
						OP_READ_RANK: begin
							ptr_d = IDX_W'(item.rank_index);
						end
						default: begin
							ptr_d = '0;
						end
					endcase
					req.rd_addr = ptr_d;
				end
			end
			S_INS_SCAN: begin
				if (goes_after) begin
					// move this entry down one place, fetch the one above
					req.wr_en   = 1'b1;
					req.wr_addr = ptr_q + IDX_W'(1);
					req.wr_data = rd_data;
					if (ptr_q != '0) begin
						req.rd_en   = 1'b1;
						req.rd_addr = ptr_q - IDX_W'(1);
						ptr_d       = ptr_q - IDX_W'(1);
					end
				end else begin
					ptr_d = ptr_q + IDX_W'(1);
				end
			end
			S_INS_WRITE: begin
				if (out_free) begin
					req.wr_en       = 1'b1;
					req.wr_addr     = ptr_q;
					req.wr_data     = item_q.rec;
					fill_d          = fill_q + CNT_W'(1);
					res_valid       = 1'b1;
					res.status      = ST_OK;
					res.rec         = item_q.rec;
					res.rank        = 6'(ptr_q);
					res.entry_total = 7'(fill_d);
				end
			end
			S_FIND: begin
				if (hit) begin
					if (out_free) begin
						res_valid  = 1'b1;
						res.status = ST_OK;
						res.rec    = rd_data;
						res.rank   = 6'(ptr_q);
					end
				end else if (!last) begin
					req.rd_en   = 1'b1;
					req.rd_addr = ptr_q + IDX_W'(1);
					ptr_d       = ptr_q + IDX_W'(1);
				end
			end
			S_RANK: begin
				if (out_free) begin
					res_valid  = 1'b1;
					res.status = ST_OK;
					res.rec    = rd_data;
					res.rank   = 6'(ptr_q);
				end
			end
			S_EMPTY: begin
				res_valid = out_free;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		ptr_q    <= ptr_d;
		status_q <= status_d;
	end

endmodule

### design/ranked_record_table.sv
// ranked record table top level: stream ports, result register, memory and sequencer
// depends on rrt_pkg, rrt_mem, rrt_ctrl
// operation: read by rank returns the entry at rank_index if it is held; find by id or
//   score reads entries from rank 0 upward until a hit, else returns not found; insert
//   reads from the last entry upward, moves each entry that ranks after the new record
//   down one place, then writes the record in the gap; refused inserts skip the scan
// throughput: one item at a time, taken once the last result is registered; the memory
//   read port visits one entry per cycle, which sets the scan and shift length
// reset: arst_n clears the record count and control state; no clearing pass is run
module ranked_record_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// class_num, student_id, score, name_head, name_tail, rank_index, zero pad
	input  logic [rrt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// opcode
	input  logic [rrt_pkg::USER_W-1:0]       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// class_out, student_id_out, score_out, name_head_out, name_tail_out, rank_out,
	// entry_total, zero pad
	output logic [rrt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// status
	output logic [rrt_pkg::USER_W-1:0]       m_axis_tuser
);
	import rrt_pkg::*;

	item_t    item;
	result_t  res;
	result_t  res_q;
	logic     res_valid;
	logic     out_free;
	logic     m_valid_q;
	mem_req_t req;
	record_t  rd_data;

	// unpack the input beat
	always_comb begin
		item                 = '0;
		item.opcode          = opcode_t'(s_axis_tuser);
		item.rec.class_num   = s_axis_tdata[2:0];
		item.rec.student_id  = s_axis_tdata[34:3];
		item.rec.score       = s_axis_tdata[44:35];
		item.rec.name_head   = s_axis_tdata[108:45];
		item.rec.name_tail   = s_axis_tdata[116:109];
		item.rank_index      = s_axis_tdata[122:117];
	end

	// result register: free when empty or being drained this cycle
	assign out_free = !m_valid_q || m_axis_tready;

	rrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.item      (item),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.req       (req),
		.rd_data   (rd_data)
	);

	// all records live here; the sequencer never reads and writes one entry together
	rrt_mem u_mem (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = res_q.status;
	assign m_axis_tdata  = {6'b0, res_q.entry_total, res_q.rank, res_q.rec.name_tail,
		res_q.rec.name_head, res_q.rec.score, res_q.rec.student_id, res_q.rec.class_num};

endmodule
